>>> rtl/core/lfp_pkg.sv
// Shared types and constants for the line follower proportional controller.
package lfp_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    localparam int THR_W   = 12;
    localparam int GAIN_W  = 16;
    localparam int SPEED_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // error magnitude never exceeds 1000, so ten quotient bits cover it
    localparam int QUOT_BITS = 10;
    localparam int ERR_SCALE = 1000;

    // gain * 65535 / 256000 == gain * 13107 / (2^11 * 25)
    localparam int PROD_W = GAIN_W + QUOT_BITS;
    localparam logic [13:0] CORR_MUL = 14'd13107;
    localparam int CORR_SHIFT = 11;
    localparam int SCALED_W = 29;
    localparam logic [29:0] RECIP_25 = 30'd687194768;
    localparam int RECIP_SHIFT = 34;
    localparam int CORR_W = 25;

    localparam logic [SPEED_W-1:0] FULL_SCALE = 16'hFFFF;

    localparam logic [THR_W-1:0]   THRESHOLD_RST = 12'd2000;
    localparam logic [GAIN_W-1:0]  GAIN_RST      = 16'd128;
    localparam logic [SPEED_W-1:0] BASE_RST      = 16'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_THRESHOLD = 2'd0,
        REG_GAIN           = 2'd1,
        REG_BASE_SPEED     = 2'd2
    } cfg_reg_t;

    // side info traveling with a request down the pipe
    typedef struct packed {
        logic line;
        logic neg;
    } lfp_ctl_t;

endpackage

>>> rtl/core/lfp_front.sv
// Input stage: line detect, sample sum and scaled error magnitude.
module lfp_front
    import lfp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int NUM_W = SAMPLE_BITS + QUOT_BITS,
    parameter int DEN_W = SAMPLE_BITS + 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] left_sample,
    input  logic [SAMPLE_BITS-1:0] middle_sample,
    input  logic [SAMPLE_BITS-1:0] right_sample,
    input  logic [THR_W-1:0]       threshold,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lfp_ctl_t               out_ctl,
    output logic [NUM_W-1:0]       out_num,
    output logic [DEN_W-1:0]       out_den
);

    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    logic                   valid_reg;
    lfp_ctl_t               ctl_reg, ctl_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [DEN_W-1:0]       den_reg, den_next;
    logic                   found;
    logic [SAMPLE_BITS-1:0] mag;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        found = (CMP_W'(left_sample) > CMP_W'(threshold))
             || (CMP_W'(middle_sample) > CMP_W'(threshold))
             || (CMP_W'(right_sample) > CMP_W'(threshold));
        den_next = DEN_W'(left_sample) + DEN_W'(middle_sample) + DEN_W'(right_sample);
        ctl_next.neg  = right_sample < left_sample;
        ctl_next.line = found && (den_next != '0);
        mag = ctl_next.neg ? (left_sample - right_sample) : (right_sample - left_sample);
        num_next = NUM_W'(mag) * NUM_W'(ERR_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ctl_reg <= ctl_next;
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;

endmodule

>>> rtl/core/lfp_div_cell.sv
// One divider cell: resolves a single quotient bit and passes the remainder on.
module lfp_div_cell
    import lfp_pkg::*;
#(
    parameter int NUM_W = SAMPLE_BITS_DEF + QUOT_BITS,
    parameter int DEN_W = SAMPLE_BITS_DEF + 2,
    parameter int SHIFT = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lfp_ctl_t             in_ctl,
    input  logic [NUM_W-1:0]     in_rem,
    input  logic [DEN_W-1:0]     in_den,
    input  logic [QUOT_BITS-1:0] in_quot,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lfp_ctl_t             out_ctl,
    output logic [NUM_W-1:0]     out_rem,
    output logic [DEN_W-1:0]     out_den,
    output logic [QUOT_BITS-1:0] out_quot
);

    localparam int CMP_W = NUM_W + 1;

    logic                 valid_reg;
    lfp_ctl_t             ctl_reg;
    logic [NUM_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg;
    logic [QUOT_BITS-1:0] quot_reg, quot_next;
    logic [CMP_W-1:0]     step;
    logic                 take;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        step      = CMP_W'(in_den) << SHIFT;
        take      = {1'b0, in_rem} >= step;
        rem_next  = take ? (in_rem - step[NUM_W-1:0]) : in_rem;
        quot_next = in_quot | (QUOT_BITS'(take) << SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ctl_reg  <= in_ctl;
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            quot_reg <= quot_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quot  = quot_reg;

endmodule

>>> rtl/core/lfp_back.sv
// Correction scaling, wheel speed saturation and output register.
module lfp_back
    import lfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lfp_ctl_t             in_ctl,
    input  logic [QUOT_BITS-1:0] in_quot,
    input  logic [GAIN_W-1:0]    gain,
    input  logic [SPEED_W-1:0]   base,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SPEED_W-1:0]   left_pwm,
    output logic [SPEED_W-1:0]   right_pwm,
    output logic                 line_found
);

    localparam int MUL2_W = PROD_W + $bits(CORR_MUL);
    localparam int MUL3_W = SCALED_W + $bits(RECIP_25);
    localparam int SPD_W  = CORR_W + 2;

    function automatic logic [SPEED_W-1:0] sat_speed(input logic signed [SPD_W-1:0] v);
        logic [SPEED_W-1:0] r;
        begin
            if (v < 0)
                r = '0;
            else if (v > $signed(SPD_W'(FULL_SCALE)))
                r = FULL_SCALE;
            else
                r = v[SPEED_W-1:0];
            return r;
        end
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;

    lfp_ctl_t             ctl1_reg, ctl2_reg, ctl3_reg;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [MUL2_W-1:0]    mul2;
    logic [SCALED_W-1:0]  scaled_reg, scaled_next;
    logic [MUL3_W-1:0]    mul3;
    logic [CORR_W-1:0]    corr_reg, corr_next;

    logic signed [SPD_W-1:0] corr_s, spd_l, spd_r;
    logic [SPEED_W-1:0]      left_next, right_next;
    logic [SPEED_W-1:0]      left_reg, right_reg;
    logic                    line_reg;

    assign r4 = !v4_reg || !out_stall;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    always_comb
    begin
        prod_next   = PROD_W'(in_quot) * PROD_W'(gain);
        mul2        = MUL2_W'(prod_reg) * MUL2_W'(CORR_MUL);
        scaled_next = mul2[CORR_SHIFT +: SCALED_W];
        mul3        = MUL3_W'(scaled_reg) * MUL3_W'(RECIP_25);
        corr_next   = mul3[RECIP_SHIFT +: CORR_W];

        corr_s = ctl3_reg.neg ? -$signed(SPD_W'(corr_reg)) : $signed(SPD_W'(corr_reg));
        spd_l  = $signed(SPD_W'(base)) - corr_s;
        spd_r  = $signed(SPD_W'(base)) + corr_s;
        if (ctl3_reg.line)
        begin
            left_next  = FULL_SCALE - sat_speed(spd_l);
            right_next = FULL_SCALE - sat_speed(spd_r);
        end
        else
        begin
            left_next  = '0;
            right_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            ctl1_reg <= in_ctl;
            prod_reg <= prod_next;
        end
        if (r2 && v1_reg)
        begin
            ctl2_reg   <= ctl1_reg;
            scaled_reg <= scaled_next;
        end
        if (r3 && v2_reg)
        begin
            ctl3_reg <= ctl2_reg;
            corr_reg <= corr_next;
        end
        if (r4 && v3_reg)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            line_reg  <= ctl3_reg.line;
        end
    end

    assign out_valid  = v4_reg;
    assign left_pwm   = left_reg;
    assign right_pwm  = right_reg;
    assign line_found = line_reg;

endmodule

>>> rtl/core/line_follow_p_controller.sv
// Three-sensor line follower proportional controller, top level.
// Takes one request per clock while in_stall is low and returns one result per request, in order.
// The pipe holds one input stage, a chain of ten divider cells that
// each settle one bit of the position error, three stages that scale the
// correction, and the output register. Every stage has its own valid bit, so
// while the output is stalled the requests behind it close up the empty slots,
// and in_stall rises only once all fifteen stages are full. Configuration
// writes go straight to the registers and are expected while the pipe is empty.
module line_follow_p_controller
    import lfp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] left_sample,
    input  logic [SAMPLE_BITS-1:0] middle_sample,
    input  logic [SAMPLE_BITS-1:0] right_sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SPEED_W-1:0]     left_pwm,
    output logic [SPEED_W-1:0]     right_pwm,
    output logic                   line_found
);

    localparam int NUM_W = SAMPLE_BITS + QUOT_BITS;
    localparam int DEN_W = SAMPLE_BITS + 2;

    logic [THR_W-1:0]   thr_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [SPEED_W-1:0] base_reg;

    logic [QUOT_BITS:0]   div_valid;
    logic [QUOT_BITS:0]   div_ready;
    lfp_ctl_t             div_ctl  [QUOT_BITS+1];
    logic [NUM_W-1:0]     div_rem  [QUOT_BITS+1];
    logic [DEN_W-1:0]     div_den  [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] div_quot [QUOT_BITS+1];
    logic                 front_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RST;
            gain_reg <= GAIN_RST;
            base_reg <= BASE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LINE_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                REG_GAIN:           gain_reg <= cfg_data[GAIN_W-1:0];
                REG_BASE_SPEED:     base_reg <= cfg_data[SPEED_W-1:0];
                default:            ;
            endcase
        end
    end

    lfp_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .NUM_W       (NUM_W),
        .DEN_W       (DEN_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (front_ready),
        .left_sample   (left_sample),
        .middle_sample (middle_sample),
        .right_sample  (right_sample),
        .threshold     (thr_reg),
        .out_valid     (div_valid[0]),
        .out_ready     (div_ready[0]),
        .out_ctl       (div_ctl[0]),
        .out_num       (div_rem[0]),
        .out_den       (div_den[0])
    );

    assign div_quot[0] = '0;
    assign in_stall    = !front_ready;

    // quotient bits resolved MSB first, one per cell
    for (genvar i = 0; i < QUOT_BITS; i++)
    begin : g_div
        lfp_div_cell #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W),
            .SHIFT (QUOT_BITS - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_ctl    (div_ctl[i]),
            .in_rem    (div_rem[i]),
            .in_den    (div_den[i]),
            .in_quot   (div_quot[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_ctl   (div_ctl[i+1]),
            .out_rem   (div_rem[i+1]),
            .out_den   (div_den[i+1]),
            .out_quot  (div_quot[i+1])
        );
    end

    lfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid[QUOT_BITS]),
        .in_ready   (div_ready[QUOT_BITS]),
        .in_ctl     (div_ctl[QUOT_BITS]),
        .in_quot    (div_quot[QUOT_BITS]),
        .gain       (gain_reg),
        .base       (base_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .left_pwm   (left_pwm),
        .right_pwm  (right_pwm),
        .line_found (line_found)
    );

    a_no_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !line_found) |-> (left_pwm == '0 && right_pwm == '0))
        else $error("compare values not zero without a line");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> div_valid[0])
        else $error("accepted request missing from input stage");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> div_valid[0])
        else $error("input stalled with empty input stage");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid[QUOT_BITS] && div_ctl[QUOT_BITS].line)
            |-> div_quot[QUOT_BITS] <= QUOT_BITS'(ERR_SCALE))
        else $error("error magnitude above full scale");

endmodule

>>> bench/tb.sv
// Self-checking testbench for the line follower proportional controller.
`timescale 1ns / 1ps

module tb;
    import lfp_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam longint SPEED_MAX = 65535;
    localparam longint GAIN_DIV = 256000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int PHASES = 12;
    localparam int PHASE_REQS = 120;
    localparam int SETTLE = 20;

    typedef struct packed {
        logic [SPEED_W-1:0] left_pwm;
        logic [SPEED_W-1:0] right_pwm;
        logic               line_found;
    } drive_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic [SB-1:0]        l;
        logic [SB-1:0]        m;
        logic [SB-1:0]        r;
        logic                 typed;
        drive_t               want;
    } step_t;

    localparam drive_t NO_LINE = '{16'd0, 16'd0, 1'b0};
    localparam drive_t CENTERED = '{16'd32767, 16'd32767, 1'b1};

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [SB-1:0]        left_sample;
    logic [SB-1:0]        middle_sample;
    logic [SB-1:0]        right_sample;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [SPEED_W-1:0]   left_pwm;
    logic [SPEED_W-1:0]   right_pwm;
    logic                 line_found;

    // predictor copy of the registers
    logic [THR_W-1:0]   thr_q;
    logic [GAIN_W-1:0]  gain_q;
    logic [SPEED_W-1:0] base_q;

    drive_t pwm_due[$];
    int     mismatches = 0;
    logic   idle_on = 1'b1;
    logic   stall_on = 1'b1;

    step_t dir_steps [28] = '{
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd0, 12'd0, 12'd0, 1'b1, NO_LINE},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd4095, 12'd4095, 12'd4095, 1'b1, CENTERED},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd4095, 12'd0, 12'd0, 1'b1,
          '{16'd0, 16'd65534, 1'b1}},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd0, 12'd0, 12'd4095, 1'b1,
          '{16'd65534, 16'd0, 1'b1}},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd2000, 12'd2000, 12'd2000, 1'b1, NO_LINE},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd0, 12'd2001, 12'd0, 1'b1, CENTERED},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd1000, 12'd2500, 12'd3000, 1'b0, NO_LINE},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd3500, 12'd100, 12'd1, 1'b0, NO_LINE},
        '{ROW_CFG, REG_GAIN, 16'd65535, 12'd0, 12'd0, 12'd0, 1'b0, NO_LINE},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd4095, 12'd0, 12'd0, 1'b1,
          '{16'd0, 16'd65535, 1'b1}},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd0, 12'd0, 12'd4095, 1'b1,
          '{16'd65535, 16'd0, 1'b1}},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd2100, 12'd0, 12'd2099, 1'b0, NO_LINE},
        '{ROW_CFG, REG_BASE_SPEED, 16'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_LINE},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd4095, 12'd4095, 12'd4095, 1'b1,
          '{16'd65535, 16'd65535, 1'b1}},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd2001, 12'd4095, 12'd0, 1'b0, NO_LINE},
        '{ROW_CFG, REG_BASE_SPEED, 16'd65535, 12'd0, 12'd0, 12'd0, 1'b0, NO_LINE},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd4095, 12'd4095, 12'd4095, 1'b1,
          '{16'd0, 16'd0, 1'b1}},
        // upper data bits must be dropped: threshold becomes zero
        '{ROW_CFG, REG_LINE_THRESHOLD, 16'hF000, 12'd0, 12'd0, 12'd0, 1'b0, NO_LINE},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd0, 12'd0, 12'd1, 1'b1,
          '{16'd65535, 16'd0, 1'b1}},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd0, 12'd0, 12'd0, 1'b1, NO_LINE},
        '{ROW_CFG, REG_LINE_THRESHOLD, 16'd4095, 12'd0, 12'd0, 12'd0, 1'b0, NO_LINE},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd4095, 12'd4095, 12'd4095, 1'b1, NO_LINE},
        // unmapped index, must not touch any register
        '{ROW_CFG, REG_UNUSED, 16'd1, 12'd0, 12'd0, 12'd0, 1'b0, NO_LINE},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd4095, 12'd4095, 12'd4095, 1'b1, NO_LINE},
        '{ROW_CFG, REG_GAIN, 16'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_LINE},
        '{ROW_CFG, REG_LINE_THRESHOLD, 16'd100, 12'd0, 12'd0, 12'd0, 1'b0, NO_LINE},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd200, 12'd50, 12'd4000, 1'b0, NO_LINE},
        '{ROW_REQ, REG_GAIN, 16'd0, 12'd4095, 12'd4095, 12'd0, 1'b0, NO_LINE}
    };

    line_follow_p_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .left_sample   (left_sample),
        .middle_sample (middle_sample),
        .right_sample  (right_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_pwm      (left_pwm),
        .right_pwm     (right_pwm),
        .line_found    (line_found)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic longint clamp_speed(input longint v);
        if (v < 0)
            return 0;
        if (v > SPEED_MAX)
            return SPEED_MAX;
        return v;
    endfunction

    function automatic drive_t steer_predict(input logic [SB-1:0] l, m, r);
        longint sum;
        longint diff;
        longint err;
        longint corr;
        drive_t res;
        res = NO_LINE;
        sum = longint'(l) + longint'(m) + longint'(r);
        if (!(l > thr_q || m > thr_q || r > thr_q) || sum == 0)
            return res;
        diff = longint'(r) - longint'(l);
        err = (diff * ERR_SCALE) / sum;
        corr = (longint'(gain_q) * err * SPEED_MAX) / GAIN_DIV;
        res.left_pwm = 16'(SPEED_MAX - clamp_speed(longint'(base_q) - corr));
        res.right_pwm = 16'(SPEED_MAX - clamp_speed(longint'(base_q) + corr));
        res.line_found = 1'b1;
        return res;
    endfunction

    // write one register; drops cfg_write again before returning so writes never abut
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_LINE_THRESHOLD: thr_q = data[THR_W-1:0];
            REG_GAIN:           gain_q = data;
            REG_BASE_SPEED:     base_q = data;
            default:            ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // in_valid stays high on return so back-to-back requests never toggle it
    task automatic send_req(input logic [SB-1:0] l, m, r, input logic typed,
                            input drive_t want);
        while (idle_on && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        left_sample   <= l;
        middle_sample <= m;
        right_sample  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pwm_due.push_back(typed ? want : steer_predict(l, m, r));
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pwm_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
        out_stall <= stall_on && ($urandom_range(0, 99) < 25);

    always @(posedge clk)
    begin
        drive_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pwm_due.size() == 0)
            begin
                $display("%0t: result with none pending: left_pwm %0d right_pwm %0d line %0d",
                         $time, left_pwm, right_pwm, line_found);
                mismatches++;
            end
            else
            begin
                want = pwm_due.pop_front();
                if (left_pwm !== want.left_pwm)
                begin
                    $display("%0t: left_pwm expected %0d got %0d",
                             $time, want.left_pwm, left_pwm);
                    mismatches++;
                end
                if (right_pwm !== want.right_pwm)
                begin
                    $display("%0t: right_pwm expected %0d got %0d",
                             $time, want.right_pwm, right_pwm);
                    mismatches++;
                end
                if (line_found !== want.line_found)
                begin
                    $display("%0t: line_found expected %0d got %0d",
                             $time, want.line_found, line_found);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int ph;
        int k;
        int hot;
        int mode;
        logic [SB-1:0] smp [3];
        logic [CFG_W-1:0] val;

        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= REG_LINE_THRESHOLD;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        left_sample   <= '0;
        middle_sample <= '0;
        right_sample  <= '0;
        thr_q  = THRESHOLD_RST;
        gain_q = GAIN_RST;
        base_q = BASE_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_steps[i])
        begin
            if (dir_steps[i].kind == ROW_CFG)
            begin
                drain_pipe();
                cfg_put(dir_steps[i].idx, dir_steps[i].data);
            end
            else
                send_req(dir_steps[i].l, dir_steps[i].m, dir_steps[i].r,
                         dir_steps[i].typed, dir_steps[i].want);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_pipe();
            idle_on  = (ph != 2);
            stall_on = (ph != 2);

            case ($urandom_range(0, 3))
                0: val = 16'd0;
                1: val = 16'hFFFF;
                2: val = 16'($urandom_range(1500, 2500));
                default: val = 16'($urandom_range(0, 65535));
            endcase
            cfg_put(REG_LINE_THRESHOLD, val);
            case ($urandom_range(0, 3))
                0: val = 16'd0;
                1: val = 16'hFFFF;
                2: val = 16'($urandom_range(0, 512));
                default: val = 16'($urandom_range(0, 65535));
            endcase
            cfg_put(REG_GAIN, val);
            case ($urandom_range(0, 3))
                0: val = 16'd0;
                1: val = 16'hFFFF;
                2: val = BASE_RST;
                default: val = 16'($urandom_range(0, 65535));
            endcase
            cfg_put(REG_BASE_SPEED, val);
            if ($urandom_range(0, 3) == 0)
                cfg_put(REG_UNUSED, 16'($urandom_range(0, 65535)));

            for (k = 0; k < PHASE_REQS; k++)
            begin
                // mid-phase hold-off until the pipe is empty
                if (ph == 5 && k == PHASE_REQS / 2)
                    drain_pipe();
                mode = $urandom_range(0, 9);
                for (int j = 0; j < 3; j++)
                    smp[j] = SB'($urandom_range(0, 4095));
                if (mode <= 5)
                begin
                    hot = $urandom_range(0, 2);
                    if (thr_q < 4095)
                        smp[hot] = SB'($urandom_range(thr_q + 1, 4095));
                end
                else if (mode == 8)
                begin
                    for (int j = 0; j < 3; j++)
                        smp[j] = SB'($urandom_range(0, 15));
                end
                else if (mode == 9)
                begin
                    for (int j = 0; j < 3; j++)
                        smp[j] = SB'($urandom_range(0, thr_q));
                end
                send_req(smp[0], smp[1], smp[2], 1'b0, NO_LINE);
            end
        end

        drain_pipe();
        if (mismatches == 0 && pwm_due.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lfp_pkg.sv
rtl/core/lfp_front.sv
rtl/core/lfp_div_cell.sv
rtl/core/lfp_back.sv
rtl/core/line_follow_p_controller.sv
bench/tb.sv
